@@ design/stepper_focus_position_controller_defines.svh @@
// assertion macros used by the focuser core module
`ifndef STEPPER_FOCUS_POSITION_CONTROLLER_DEFINES_SVH
`define STEPPER_FOCUS_POSITION_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SFPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfpc assertion failed");

// next-cycle implication, disabled while in reset
`define SFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfpc assertion failed");

`endif

@@ design/sfpc_pkg.sv @@
// shared constants, codes and types of the focuser position controller
package sfpc_pkg;

  localparam int POSITION_BITS_DEF = 20;
  localparam int BACKLASH_BITS_DEF = 12;

  localparam int DELAY_BITS = 16;
  localparam int CNT_BITS   = 17;
  localparam int MODE_BITS  = 3;
  localparam int KIND_BITS  = 3;

  localparam logic [31:0]           MAX_POS_RESET    = 32'd100000;
  localparam logic [DELAY_BITS-1:0] STEP_DELAY_RESET = 16'd1000;
  localparam logic [DELAY_BITS-1:0] STEP_DELAY_MIN   = 16'd50;
  localparam int                    PULSE_US         = 10;
  localparam logic [MODE_BITS-1:0]  MICROSTEP_MAX    = 3'd5;

  // command kinds
  localparam logic [KIND_BITS-1:0] KIND_MOVE_ABS = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_MOVE_REL = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_SYNC     = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_ABORT    = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_TICK     = 3'd4;

  // register indexes
  localparam logic [2:0] REG_MAX_POS    = 3'd0;
  localparam logic [2:0] REG_BACKLASH   = 3'd1;
  localparam logic [2:0] REG_REVERSE    = 3'd2;
  localparam logic [2:0] REG_STEP_DELAY = 3'd3;
  localparam logic [2:0] REG_MICROSTEP  = 3'd4;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic                 status;
    logic                 step_pulse;
    logic                 dir_level;
    logic                 moving;
    logic                 motion_done;
    logic [MODE_BITS-1:0] mode_pins;
  } res_flags_t;

  // microstep resolution to m2,m1,m0
  function automatic logic [MODE_BITS-1:0] mode_pins_of(input logic [MODE_BITS-1:0] sel);
    logic [MODE_BITS-1:0] pins;
    case (sel)
      3'd0: pins = 3'd0;
      3'd1: pins = 3'd1;
      3'd2: pins = 3'd2;
      3'd3: pins = 3'd3;
      3'd4: pins = 3'd4;
      3'd5: pins = 3'd5;
      default: pins = 3'd0;
    endcase
    return pins;
  endfunction

endpackage

@@ design/sfpc_cfg.sv @@
// configuration registers behind the apb port
module sfpc_cfg import sfpc_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int BACKLASH_BITS = BACKLASH_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic [POSITION_BITS-1:0] max_position,
  output logic [BACKLASH_BITS-1:0] backlash_steps,
  output logic                     reverse_direction,
  output logic [DELAY_BITS-1:0]    step_delay_us,
  output logic [MODE_BITS-1:0]     microstep_select
);

  logic [POSITION_BITS-1:0] max_pos_r;
  logic [BACKLASH_BITS-1:0] backlash_r;
  logic                     reverse_r;
  logic [DELAY_BITS-1:0]    delay_r;
  logic [MODE_BITS-1:0]     microstep_r;
  logic                     wr_en;
  logic [2:0]               reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pos_r   <= MAX_POS_RESET[POSITION_BITS-1:0];
      backlash_r  <= '0;
      reverse_r   <= 1'b0;
      delay_r     <= STEP_DELAY_RESET;
      microstep_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_POS:    max_pos_r  <= pwdata[POSITION_BITS-1:0];
        REG_BACKLASH:   backlash_r <= pwdata[BACKLASH_BITS-1:0];
        REG_REVERSE:    reverse_r  <= pwdata[0];
        REG_STEP_DELAY: begin
          // too short a delay is dropped
          if (pwdata[DELAY_BITS-1:0] >= STEP_DELAY_MIN) delay_r <= pwdata[DELAY_BITS-1:0];
        end
        REG_MICROSTEP: begin
          if (pwdata[MODE_BITS-1:0] <= MICROSTEP_MAX) microstep_r <= pwdata[MODE_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MAX_POS:    prdata = 32'(max_pos_r);
      REG_BACKLASH:   prdata = 32'(backlash_r);
      REG_REVERSE:    prdata = 32'(reverse_r);
      REG_STEP_DELAY: prdata = 32'(delay_r);
      REG_MICROSTEP:  prdata = 32'(microstep_r);
      default:        prdata = '0;
    endcase
  end

  assign max_position      = max_pos_r;
  assign backlash_steps    = backlash_r;
  assign reverse_direction = reverse_r;
  assign step_delay_us     = delay_r;
  assign microstep_select  = microstep_r;

endmodule

@@ design/sfpc_core.sv @@
// motion state and the per-beat command logic
module sfpc_core import sfpc_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int BACKLASH_BITS = BACKLASH_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [KIND_BITS-1:0]     kind,
  input  logic [POSITION_BITS:0]   value,
  input  logic [POSITION_BITS-1:0] max_position,
  input  logic [BACKLASH_BITS-1:0] backlash_steps,
  input  logic                     reverse_direction,
  input  logic [DELAY_BITS-1:0]    step_delay_us,
  input  logic [MODE_BITS-1:0]     microstep_select,
  output res_flags_t               flags,
  output logic [POSITION_BITS-1:0] position,
  output logic [POSITION_BITS-1:0] target
);

  `include "stepper_focus_position_controller_defines.svh"

  localparam int PB = POSITION_BITS;

  logic [PB-1:0]            cur_pos_r,  cur_pos_nxt;
  logic [PB-1:0]            goal_pos_r, goal_pos_nxt;
  logic                     in_motion_r, in_motion_nxt;
  dir_t                     prior_dir_r, prior_dir_nxt;
  logic [BACKLASH_BITS-1:0] backlash_r, backlash_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;

  logic [PB+1:0] val_x;
  logic [PB+1:0] tgt;
  logic          refused;
  logic [PB-1:0] tgt_pos;
  dir_t          new_dir;
  logic [PB-1:0] sync_pos;

  // requested target, two bits above the position for sign and overflow
  assign val_x   = {value[PB], value};
  assign tgt     = (kind == KIND_MOVE_ABS) ? val_x : ({2'b00, cur_pos_r} + val_x);
  assign refused = tgt[PB+1] | (tgt[PB:0] > {1'b0, max_position});
  assign tgt_pos = tgt[PB-1:0];
  assign new_dir = (tgt_pos > cur_pos_r) ? DIR_UP : DIR_DOWN;

  always_comb begin
    if (value[PB]) sync_pos = '0;
    else if (value > {1'b0, max_position}) sync_pos = max_position;
    else sync_pos = value[PB-1:0];
  end

  always_comb begin
    cur_pos_nxt   = cur_pos_r;
    goal_pos_nxt  = goal_pos_r;
    in_motion_nxt = in_motion_r;
    prior_dir_nxt = prior_dir_r;
    backlash_nxt  = backlash_r;
    cnt_nxt       = cnt_r;
    flags             = '0;
    flags.mode_pins   = mode_pins_of(microstep_select);
    case (kind)
      KIND_MOVE_ABS, KIND_MOVE_REL: begin
        if (refused) begin
          flags.status = 1'b1;
        end else if (tgt_pos != cur_pos_r) begin
          // reversal takes up the gear slack first
          if (prior_dir_r != DIR_NONE && new_dir != prior_dir_r && backlash_steps != '0)
            backlash_nxt = backlash_steps;
          else
            backlash_nxt = '0;
          goal_pos_nxt  = tgt_pos;
          prior_dir_nxt = new_dir;
          in_motion_nxt = 1'b1;
          cnt_nxt       = '0;
        end
      end
      KIND_SYNC: begin
        cur_pos_nxt       = sync_pos;
        goal_pos_nxt      = sync_pos;
        flags.motion_done = in_motion_r;
        in_motion_nxt     = 1'b0;
        backlash_nxt      = '0;
        cnt_nxt           = '0;
      end
      KIND_ABORT: begin
        goal_pos_nxt      = cur_pos_r;
        flags.motion_done = in_motion_r;
        in_motion_nxt     = 1'b0;
        backlash_nxt      = '0;
        cnt_nxt           = '0;
      end
      KIND_TICK: begin
        if (in_motion_r) begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
          end else if (cur_pos_r == goal_pos_r) begin
            flags.motion_done = 1'b1;
            in_motion_nxt     = 1'b0;
            backlash_nxt      = '0;
          end else begin
            flags.step_pulse = 1'b1;
            flags.dir_level  = (prior_dir_r != DIR_DOWN) ^ reverse_direction;
            if (backlash_r != '0) backlash_nxt = backlash_r - 1'b1;
            else if (prior_dir_r == DIR_DOWN) cur_pos_nxt = cur_pos_r - 1'b1;
            else cur_pos_nxt = cur_pos_r + 1'b1;
            cnt_nxt = {1'b0, step_delay_us} + CNT_BITS'(PULSE_US - 1);
          end
        end
      end
      default: ;
    endcase
    flags.moving = in_motion_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r   <= '0;
      goal_pos_r  <= '0;
      in_motion_r <= 1'b0;
      prior_dir_r <= DIR_NONE;
      backlash_r  <= '0;
      cnt_r       <= '0;
    end else if (adv) begin
      cur_pos_r   <= cur_pos_nxt;
      goal_pos_r  <= goal_pos_nxt;
      in_motion_r <= in_motion_nxt;
      prior_dir_r <= prior_dir_nxt;
      backlash_r  <= backlash_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  assign position = cur_pos_nxt;
  assign target   = goal_pos_nxt;

  `SFPC_ASSERT_NOW(a_idle_no_countdown, clk, rst_n, !in_motion_r,
    cnt_r == '0 && backlash_r == '0)
  `SFPC_ASSERT_NOW(a_idle_on_target, clk, rst_n, !in_motion_r, goal_pos_r == cur_pos_r)
  `SFPC_ASSERT_NOW(a_pulse_needs_motion, clk, rst_n, adv && flags.step_pulse,
    in_motion_r && cnt_r == '0)
  `SFPC_ASSERT_NEXT(a_done_stops, clk, rst_n, adv && flags.motion_done, !in_motion_r)

endmodule

@@ design/stepper_focus_position_controller.sv @@
// Stepper focuser motion controller, top level.
// Input stream: one beat is a command (absolute move, relative move, sync,
// abort) or a one-microsecond tick; in_tuser carries the kind and in_tdata
// the signed target, delta or sync position.
// Output stream: exactly one beat per input beat with status, step pulse,
// direction level, position, target, moving, motion_done and mode pins.
// A beat passes an input register, then the command logic and the motion
// state update, then the output register, which drives out_tvalid; one
// beat is taken every cycle while the receiver does not stall.
// The output register and the input register together let a new beat in
// while a finished result waits; when the receiver stalls, at most two beats
// are held and in_tready drops until out_tready returns.
// Reset (rst_n low, synchronous) clears position, target and motion state,
// empties both registers and loads the register defaults.
// Configuration goes through the apb port at byte addresses 4*index; the user
// must write it only while the stream is idle, which the block does not enforce.
module stepper_focus_position_controller import sfpc_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int BACKLASH_BITS = BACKLASH_BITS_DEF,
  localparam int VALUE_BITS = POSITION_BITS + 1,
  localparam int IN_W       = ((VALUE_BITS + 7) / 8) * 8,
  localparam int RES_BITS   = 2 * POSITION_BITS + 8,
  localparam int OUT_W      = ((RES_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // value
  input  logic [IN_W-1:0]      in_tdata,
  // kind
  input  logic [KIND_BITS-1:0] in_tuser,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // status, step_pulse, dir_level, position, target, moving, motion_done, mode_pins
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  logic [POSITION_BITS-1:0] max_position;
  logic [BACKLASH_BITS-1:0] backlash_steps;
  logic                     reverse_direction;
  logic [DELAY_BITS-1:0]    step_delay_us;
  logic [MODE_BITS-1:0]     microstep_select;

  logic                     s1_valid_r;
  logic [KIND_BITS-1:0]     s1_kind_r;
  logic [VALUE_BITS-1:0]    s1_value_r;
  logic                     adv;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;

  res_flags_t               flags;
  logic [POSITION_BITS-1:0] position;
  logic [POSITION_BITS-1:0] target;

  assign cfg_pready = 1'b1;

  sfpc_cfg #(
    .POSITION_BITS(POSITION_BITS),
    .BACKLASH_BITS(BACKLASH_BITS)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (cfg_psel),
    .penable          (cfg_penable),
    .pwrite           (cfg_pwrite),
    .paddr            (cfg_paddr),
    .pwdata           (cfg_pwdata),
    .prdata           (cfg_prdata),
    .max_position     (max_position),
    .backlash_steps   (backlash_steps),
    .reverse_direction(reverse_direction),
    .step_delay_us    (step_delay_us),
    .microstep_select (microstep_select)
  );

  // item moves from the input register into the output register
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r  <= in_tuser;
      s1_value_r <= in_tdata[VALUE_BITS-1:0];
    end
  end

  sfpc_core #(
    .POSITION_BITS(POSITION_BITS),
    .BACKLASH_BITS(BACKLASH_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .kind             (s1_kind_r),
    .value            (s1_value_r),
    .max_position     (max_position),
    .backlash_steps   (backlash_steps),
    .reverse_direction(reverse_direction),
    .step_delay_us    (step_delay_us),
    .microstep_select (microstep_select),
    .flags            (flags),
    .position         (position),
    .target           (target)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= OUT_W'({flags.mode_pins, flags.motion_done, flags.moving,
                            target, position, flags.dir_level, flags.step_pulse,
                            flags.status});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
